FILE: sv/key_event_ring_queue_defines.svh
// assertion macros for the key event ring queue checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef KEY_EVENT_RING_QUEUE_DEFINES_SVH
`define KEY_EVENT_RING_QUEUE_DEFINES_SVH

// consequent holds in the same cycle
`define KERQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key event ring queue check failed");

// consequent holds in the next cycle
`define KERQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key event ring queue check failed");

`endif

FILE: sv/kerq_pkg.sv
// shared types and constants of the key event ring queue
// no dependencies
package kerq_pkg;

  localparam int unsigned Entries     = 16;
  localparam int unsigned BufferBytes = 256;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned UsedW       = 9;
  localparam int unsigned OffW        = 8;
  localparam int unsigned LenW        = 6;
  localparam int unsigned CodeW       = 8;
  localparam int unsigned KeyCntW     = 5;
  localparam int unsigned CfgIdxW     = 2;

  // register indexes of the config port
  localparam logic [CfgIdxW-1:0] CfgKbdMajor   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClearMinor = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCancelMinor = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgModeMajor  = 2'd3;

  typedef enum logic [2:0] {
    KIND_WRITE, KIND_BYTE, KIND_READ, KIND_PEEK,
    KIND_FLUSH_CLEAR, KIND_FLUSH_CANCEL, KIND_CLEAR_ALL, KIND_NOP
  } kind_e;

  typedef enum logic [2:0] {
    ST_SUCCESS, ST_EMPTY, ST_KEY_FOUND, ST_KEY_NOT_FOUND, ST_WRITE_OK, ST_WRITE_REJ
  } status_e;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_BYTES, S_FLUSH} state_e;

  typedef enum logic [2:0] {EMIT_NONE, EMIT_STATUS, EMIT_MODE, EMIT_HEADER, EMIT_BYTE} emit_e;

  typedef struct packed {
    logic [CodeW-1:0] major;
    logic [CodeW-1:0] minor;
    logic [CodeW-1:0] mode;
    logic [LenW-1:0]  len;
    logic [OffW-1:0]  off;
  } desc_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    hdr_write;
    logic    byte_write;
    logic    set_mode;
    logic    pop;
    logic    pop_read;
    logic    clear_all;
    logic    rd_start;
    emit_e   emit;
    status_e code;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  hdr_reject;
    logic  pend_ok;
    logic  mode_diff;
    logic  empty;
    logic  len_zero;
    logic  last_byte;
    logic  ovf_hit;
    logic  cnt_zero;
    logic  key_hit;
  } stat_t;

endpackage

FILE: sv/kerq_ctrl.sv
// controller state machine of the key event ring queue
// depends on kerq_pkg
module kerq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  kerq_pkg::stat_t stat_i,
  output kerq_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import kerq_pkg::*;

  state_e state_q, state_d;
  logic   is_read;

  assign is_read = (stat_i.kind == KIND_READ);
  assign busy_o  = (state_q != S_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (stat_i.kind)
          KIND_READ, KIND_PEEK: begin
            if (!stat_i.mode_diff && !stat_i.empty && !stat_i.len_zero) state_d = S_BYTES;
          end
          KIND_FLUSH_CLEAR, KIND_FLUSH_CANCEL: begin
            if (!stat_i.ovf_hit && !stat_i.cnt_zero) state_d = S_FLUSH;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_BYTES: begin
        if (stat_i.last_byte) state_d = S_IDLE;
      end
      S_FLUSH: begin
        if (stat_i.empty || stat_i.key_hit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.emit = EMIT_NONE;
    cmd_o.code = ST_SUCCESS;
    unique case (state_q)
      S_IDLE: cmd_o.latch = start_i;
      S_EXEC: begin
        unique case (stat_i.kind)
          KIND_WRITE: begin
            cmd_o.hdr_write = 1'b1;
            cmd_o.emit      = EMIT_STATUS;
            cmd_o.code      = stat_i.hdr_reject ? ST_WRITE_REJ : ST_WRITE_OK;
          end
          KIND_BYTE: begin
            cmd_o.byte_write = 1'b1;
            cmd_o.emit       = EMIT_STATUS;
            cmd_o.code       = stat_i.pend_ok ? ST_WRITE_OK : ST_WRITE_REJ;
          end
          KIND_READ, KIND_PEEK: begin
            priority if (stat_i.mode_diff) begin
              cmd_o.set_mode = 1'b1;
              cmd_o.emit     = EMIT_MODE;
            end else if (stat_i.empty) begin
              cmd_o.emit = EMIT_STATUS;
              cmd_o.code = ST_EMPTY;
            end else begin
              cmd_o.emit     = EMIT_HEADER;
              cmd_o.rd_start = 1'b1;
              cmd_o.pop      = stat_i.len_zero && is_read;
              cmd_o.pop_read = stat_i.len_zero && is_read;
            end
          end
          KIND_FLUSH_CLEAR, KIND_FLUSH_CANCEL: begin
            priority if (stat_i.ovf_hit) begin
              cmd_o.clear_all = 1'b1;
              cmd_o.emit      = EMIT_STATUS;
              cmd_o.code      = ST_KEY_FOUND;
            end else if (stat_i.cnt_zero) begin
              cmd_o.emit = EMIT_STATUS;
              cmd_o.code = ST_KEY_NOT_FOUND;
            end else begin
              // walk the ring in the flush state
              cmd_o.emit = EMIT_NONE;
            end
          end
          KIND_CLEAR_ALL: begin
            cmd_o.clear_all = 1'b1;
            cmd_o.emit      = EMIT_STATUS;
          end
          default: ;
        endcase
      end
      S_BYTES: begin
        cmd_o.emit     = EMIT_BYTE;
        cmd_o.pop      = stat_i.last_byte && is_read;
        cmd_o.pop_read = stat_i.last_byte && is_read;
      end
      S_FLUSH: begin
        priority if (stat_i.empty) begin
          cmd_o.emit = EMIT_STATUS;
          cmd_o.code = ST_KEY_NOT_FOUND;
        end else begin
          cmd_o.pop = 1'b1;
          if (stat_i.key_hit) begin
            cmd_o.emit = EMIT_STATUS;
            cmd_o.code = ST_KEY_FOUND;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/kerq_dp.sv
// datapath of the key event ring queue: rings, counters, flags, result mux
// depends on kerq_pkg
module kerq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kerq_pkg::cmd_t                 cmd_i,
  output kerq_pkg::stat_t                stat_o,
  input  logic [2:0]                     kind_i,
  input  logic [kerq_pkg::CodeW-1:0]     event_major_i,
  input  logic [kerq_pkg::CodeW-1:0]     event_minor_i,
  input  logic [kerq_pkg::LenW-1:0]      payload_length_i,
  input  logic [7:0]                     payload_byte_i,
  input  logic [kerq_pkg::CodeW-1:0]     current_mode_i,
  input  logic                           cfg_we_i,
  input  logic [kerq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kerq_pkg::CodeW-1:0]     cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [2:0]                     status_o,
  output logic [kerq_pkg::CodeW-1:0]     out_major_o,
  output logic [kerq_pkg::CodeW-1:0]     out_minor_o,
  output logic [kerq_pkg::LenW-1:0]      out_length_o,
  output logic [7:0]                     out_byte_o,
  output logic                           is_payload_o,
  output logic                           last_o
);
  import kerq_pkg::*;

  // latched request
  kind_e            kind_q;
  logic [CodeW-1:0] emaj_q, emin_q, cmode_q;
  logic [LenW-1:0]  plen_q;
  logic [7:0]       pbyte_q;

  // config registers
  logic [CodeW-1:0] kbd_major_q, clear_minor_q, cancel_minor_q, mode_major_q;

  // queue state
  desc_t              desc_q [Entries];
  logic [SlotW-1:0]   rd_slot_q, wr_slot_q;
  logic [CountW-1:0]  count_q;
  logic [UsedW-1:0]   used_q;
  logic [OffW-1:0]    wr_off_q;
  logic               full_q, clear_ovf_q, cancel_ovf_q;
  logic [KeyCntW-1:0] clear_cnt_q, cancel_cnt_q;
  logic [CodeW-1:0]   engine_mode_q;
  logic [LenW-1:0]    pending_q;
  logic               pend_acc_q;

  // byte ring
  logic [7:0]           mem [BufferBytes];
  logic [BufferBytes-1:0] vld_q;
  logic [7:0]           rdata_q;
  logic                 rvld_q;
  logic [LenW-1:0]      idx_q;

  desc_t            head;
  logic [CodeW-1:0] mode_tgt, flush_key;
  logic [UsedW:0]   used_sum;
  logic             reject, pend_ok, mem_we, empty, last_byte;
  logic [OffW-1:0]  waddr, raddr;
  logic             is_kbd_in, is_kbd_head;

  assign head        = desc_q[rd_slot_q];
  assign empty       = (count_q == '0);
  assign used_sum    = {1'b0, used_q} + (UsedW+1)'(plen_q);
  assign reject      = full_q || (count_q >= CountW'(Entries))
                       || (used_sum > (UsedW+1)'(BufferBytes));
  assign pend_ok     = (pending_q != '0) && pend_acc_q;
  assign mem_we      = cmd_i.byte_write && pend_ok;
  assign waddr       = wr_off_q - OffW'(pending_q);
  assign raddr       = cmd_i.rd_start ? head.off : head.off + OffW'(idx_q) + OffW'(1);
  assign mode_tgt    = empty ? cmode_q : head.mode;
  assign flush_key   = (kind_q == KIND_FLUSH_CLEAR) ? clear_minor_q : cancel_minor_q;
  assign is_kbd_in   = (emaj_q == kbd_major_q);
  assign is_kbd_head = (head.major == kbd_major_q);
  assign last_byte   = (idx_q == head.len - LenW'(1));

  // status to controller
  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.hdr_reject = reject;
    stat_o.pend_ok    = pend_ok;
    stat_o.mode_diff  = (engine_mode_q != mode_tgt);
    stat_o.empty      = empty;
    stat_o.len_zero   = (head.len == '0);
    stat_o.last_byte  = last_byte;
    stat_o.ovf_hit    = (kind_q == KIND_FLUSH_CLEAR) ? clear_ovf_q : cancel_ovf_q;
    stat_o.cnt_zero   = (kind_q == KIND_FLUSH_CLEAR) ? (clear_cnt_q == '0)
                                                      : (cancel_cnt_q == '0);
    stat_o.key_hit    = is_kbd_head && (head.minor == flush_key);
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_e'(kind_i);
      emaj_q  <= event_major_i;
      emin_q  <= event_minor_i;
      plen_q  <= payload_length_i;
      pbyte_q <= payload_byte_i;
      cmode_q <= current_mode_i;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_major_q    <= 8'd0;
      clear_minor_q  <= 8'd0;
      cancel_minor_q <= 8'd1;
      mode_major_q   <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKbdMajor:    kbd_major_q    <= cfg_wdata_i;
        CfgClearMinor:  clear_minor_q  <= cfg_wdata_i;
        CfgCancelMinor: cancel_minor_q <= cfg_wdata_i;
        CfgModeMajor:   mode_major_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // descriptor ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) desc_q[i] <= '0;
    end else if (cmd_i.clear_all) begin
      for (int i = 0; i < Entries; i++) desc_q[i] <= '0;
    end else if (cmd_i.hdr_write && !reject) begin
      desc_q[wr_slot_q] <= '{major: emaj_q, minor: emin_q, mode: cmode_q,
                             len: plen_q, off: wr_off_q};
    end
  end

  // queue counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q     <= '0;
      wr_slot_q     <= '0;
      count_q       <= '0;
      used_q        <= '0;
      wr_off_q      <= '0;
      full_q        <= 1'b0;
      clear_ovf_q   <= 1'b0;
      cancel_ovf_q  <= 1'b0;
      clear_cnt_q   <= '0;
      cancel_cnt_q  <= '0;
      engine_mode_q <= '0;
      pending_q     <= '0;
      pend_acc_q    <= 1'b0;
      idx_q         <= '0;
    end else begin
      if (cmd_i.clear_all) begin
        rd_slot_q    <= '0;
        wr_slot_q    <= '0;
        count_q      <= '0;
        used_q       <= '0;
        wr_off_q     <= '0;
        full_q       <= 1'b0;
        clear_ovf_q  <= 1'b0;
        cancel_ovf_q <= 1'b0;
        clear_cnt_q  <= '0;
        cancel_cnt_q <= '0;
        pending_q    <= '0;
        pend_acc_q   <= 1'b0;
      end
      // header write
      if (cmd_i.hdr_write) begin
        pending_q  <= plen_q;
        pend_acc_q <= !reject;
        if (reject) begin
          full_q <= 1'b1;
          if (is_kbd_in) begin
            priority if (emin_q == clear_minor_q) begin
              clear_ovf_q <= 1'b1;
            end else if (emin_q == cancel_minor_q) begin
              cancel_ovf_q <= 1'b1;
            end else begin
            end
          end
        end else begin
          if (is_kbd_in) begin
            priority if (emin_q == clear_minor_q) begin
              if (clear_cnt_q != '1) clear_cnt_q <= clear_cnt_q + KeyCntW'(1);
            end else if (emin_q == cancel_minor_q) begin
              if (cancel_cnt_q != '1) cancel_cnt_q <= cancel_cnt_q + KeyCntW'(1);
            end else begin
            end
          end
          count_q   <= count_q + CountW'(1);
          used_q    <= used_sum[UsedW-1:0];
          wr_slot_q <= (wr_slot_q == SlotW'(Entries-1)) ? '0 : wr_slot_q + SlotW'(1);
          wr_off_q  <= wr_off_q + OffW'(plen_q);
        end
      end
      // payload byte
      if (cmd_i.byte_write && (pending_q != '0)) pending_q <= pending_q - LenW'(1);
      if (cmd_i.set_mode) engine_mode_q <= mode_tgt;
      // read index
      if (cmd_i.rd_start) idx_q <= '0;
      else if (cmd_i.emit == EMIT_BYTE) idx_q <= idx_q + LenW'(1);
      // pop head entry
      if (cmd_i.pop) begin
        count_q   <= count_q - CountW'(1);
        used_q    <= (used_q >= UsedW'(head.len)) ? used_q - UsedW'(head.len) : '0;
        rd_slot_q <= (rd_slot_q == SlotW'(Entries-1)) ? '0 : rd_slot_q + SlotW'(1);
        if (is_kbd_head) begin
          priority if (head.minor == clear_minor_q) begin
            if (clear_cnt_q != '0) clear_cnt_q <= clear_cnt_q - KeyCntW'(1);
          end else if (head.minor == cancel_minor_q) begin
            if (cancel_cnt_q != '0) cancel_cnt_q <= cancel_cnt_q - KeyCntW'(1);
          end else begin
          end
        end
        if (cmd_i.pop_read && full_q) begin
          full_q       <= 1'b0;
          clear_ovf_q  <= 1'b0;
          cancel_ovf_q <= 1'b0;
        end
      end
    end
  end

  // byte ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= pbyte_q;
    rdata_q <= mem[raddr];
    rvld_q  <= vld_q[raddr];
  end

  // written marks of the byte ring, an unwritten byte reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.clear_all) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  // result mux
  always_comb begin
    result_valid_o = (cmd_i.emit != EMIT_NONE);
    status_o       = ST_SUCCESS;
    out_major_o    = '0;
    out_minor_o    = '0;
    out_length_o   = '0;
    out_byte_o     = '0;
    is_payload_o   = 1'b0;
    last_o         = 1'b0;
    unique case (cmd_i.emit)
      EMIT_STATUS: begin
        status_o = cmd_i.code;
        last_o   = 1'b1;
      end
      EMIT_MODE: begin
        out_major_o = mode_major_q;
        out_minor_o = mode_tgt;
        last_o      = 1'b1;
      end
      EMIT_HEADER: begin
        out_major_o  = head.major;
        out_minor_o  = head.minor;
        out_length_o = head.len;
        last_o       = (head.len == '0);
      end
      EMIT_BYTE: begin
        out_byte_o   = rvld_q ? rdata_q : 8'd0;
        is_payload_o = 1'b1;
        last_o       = last_byte;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/key_event_ring_queue.sv
// Key event ring queue top level: controller plus datapath.
// Latency: the first result is on the ports in the cycle after the accepting edge, but a ring-walking flush is later.
// Throughput: a new request is taken only while idle; read/peek give the header, then one payload byte per
// cycle; flush pops one entry per cycle until the key is popped or the ring runs empty.
// Reset: async active low; rings, counters and flags empty, registers at their defaults.
// Results are shown for one cycle with result_valid_o; the receiver cannot stall.
module key_event_ring_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [2:0]                   kind_i,
  input  logic [kerq_pkg::CodeW-1:0]   event_major_i,
  input  logic [kerq_pkg::CodeW-1:0]   event_minor_i,
  input  logic [kerq_pkg::LenW-1:0]    payload_length_i,
  input  logic [7:0]                   payload_byte_i,
  input  logic [kerq_pkg::CodeW-1:0]   current_mode_i,
  input  logic                         cfg_we_i,
  input  logic [kerq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [kerq_pkg::CodeW-1:0]   cfg_wdata_i,
  output logic                         result_valid_o,
  output logic [2:0]                   status_o,
  output logic [kerq_pkg::CodeW-1:0]   out_major_o,
  output logic [kerq_pkg::CodeW-1:0]   out_minor_o,
  output logic [kerq_pkg::LenW-1:0]    out_length_o,
  output logic [7:0]                   out_byte_o,
  output logic                         is_payload_o,
  output logic                         last_o
);
  import kerq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  kerq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // storage and result path
  kerq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .event_major_i   (event_major_i),
    .event_minor_i   (event_minor_i),
    .payload_length_i(payload_length_i),
    .payload_byte_i  (payload_byte_i),
    .current_mode_i  (current_mode_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .out_major_o     (out_major_o),
    .out_minor_o     (out_minor_o),
    .out_length_o    (out_length_o),
    .out_byte_o      (out_byte_o),
    .is_payload_o    (is_payload_o),
    .last_o          (last_o)
  );

endmodule

FILE: sv/kerq_checker.sv
// port-level checks of the key event ring queue, bound to the top level
// depends on key_event_ring_queue_defines.svh
`include "key_event_ring_queue_defines.svh"

module kerq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o,
  input logic last_o
);

  // an accepted request keeps the block busy in the next cycle
  `KERQ_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  // results of one request come in consecutive cycles
  `KERQ_ASSERT_NEXT(a_burst_cont, result_valid_o && !last_o, result_valid_o)
  // the final result frees the block
  `KERQ_ASSERT_NEXT(a_last_idle, result_valid_o && last_o, !busy_o)

endmodule

bind key_event_ring_queue kerq_checker u_kerq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .last_o        (last_o)
);
